// ----- rtl/segmented_memory_access_unit_core_macros.svh -----
// assertion macros used by the checker of the segmented memory access unit
`ifndef SEGMENTED_MEMORY_ACCESS_UNIT_CORE_MACROS_SVH
`define SEGMENTED_MEMORY_ACCESS_UNIT_CORE_MACROS_SVH

// same-cycle implication, disabled while reset is low
`define SMAU_ASSERT_IMPL(label, clk, rst_n, pre, post, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (pre) |-> (post)) \
        else $error(msg);

// next-cycle implication, disabled while reset is low
`define SMAU_ASSERT_NEXT(label, clk, rst_n, pre, post, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (pre) |=> (post)) \
        else $error(msg);

`endif

// ----- rtl/smau_pkg.sv -----
// types and constants shared by the segmented memory access unit modules
package smau_pkg;

    localparam int LANES       = 4;
    localparam int CFG_IDX_W   = 3;
    localparam int QUEUE_DEPTH = 2;
    localparam int QPTR_W      = 1;
    localparam int QCNT_W      = 2;

    localparam logic [31:0] ABSENT_ENTRY = 32'hFFFF_FFFF;
    localparam logic [2:0]  SIZE_MAX     = 3'd4;

    typedef enum logic
    {
        OP_READ  = 1'b0,
        OP_WRITE = 1'b1
    } smau_op_t;

    // one classified access as it travels from the front to the back
    typedef struct packed
    {
        logic             is_write;
        logic             fault;
        logic             load_regs;
        logic [2:0]       size;
        logic [31:0]      laddr;
        logic [15:0]      phys;
        logic [31:0]      wdata;
        logic [3:0]       wr_en;
        logic [3:0]       rd_en;
        logic [3:0][7:0]  wbyte;
    } smau_item_t;

    // queue fill status
    typedef struct packed
    {
        logic full;
        logic empty;
    } smau_q_status_t;

endpackage

// ----- rtl/smau_front.sv -----
// front end: segment table, address translation and per-byte access checks
module smau_front #(
    parameter int MEM_BYTES = 16384,
    parameter int SEGMENTS  = 8
) (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            cfg_we,
    input  logic [smau_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  logic [31:0]                     cfg_wdata,
    input  logic                            op,
    input  logic [31:0]                     logical_addr,
    input  logic [2:0]                      access_size,
    input  logic [31:0]                     write_data,
    input  logic                            is_fetch,
    output smau_pkg::smau_item_t            item
);
    import smau_pkg::*;

    localparam int SEG_IDX_W = (SEGMENTS > 1) ? $clog2(SEGMENTS) : 1;

    logic [31:0]       seg_table_reg [SEGMENTS];
    logic [15:0]       seg;
    logic              seg_fault;
    logic [31:0]       entry;
    logic [15:0]       base;
    logic [16:0]       limit;
    logic              absent;
    logic [15:0]       phys;
    logic [2:0]        size_c;
    logic              is_write;
    logic              fetch;
    logic [16:0]       byte_addr [LANES];
    logic [LANES-1:0]  active;
    logic [LANES-1:0]  in_mem;
    logic [LANES-1:0]  bad;
    logic [LANES-1:0]  wr_en;
    logic [LANES-1:0]  rd_en;
    logic [3:0][7:0]   wbyte;
    logic              wr_chain;
    logic [1:0]        pos;

    // segment table; the user must write it only while idle, the block itself does not enforce this
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int s = 0; s < SEGMENTS; s++)
            begin
                seg_table_reg[s] <= ABSENT_ENTRY;
            end
        end
        else if (cfg_we && ({1'b0, cfg_index} < 4'(SEGMENTS)))
        begin
            seg_table_reg[cfg_index[SEG_IDX_W-1:0]] <= cfg_wdata;
        end
    end

    // segment lookup and translation
    assign seg       = logical_addr[31:16];
    assign seg_fault = (seg >= 16'(SEGMENTS));
    assign entry     = seg_fault ? ABSENT_ENTRY : seg_table_reg[seg[SEG_IDX_W-1:0]];
    assign base      = entry[31:16];
    assign limit     = {1'b0, base} + {1'b0, entry[15:0]};
    assign absent    = (entry == ABSENT_ENTRY);
    assign phys      = base + logical_addr[15:0];
    assign size_c    = (access_size > SIZE_MAX) ? SIZE_MAX : access_size;
    assign is_write  = (op == OP_WRITE);
    assign fetch     = is_fetch && !is_write;

    // per-byte checks, write enables stop at the first bad byte
    always_comb
    begin
        wr_chain = is_write && !seg_fault;
        for (int i = 0; i < LANES; i++)
        begin
            byte_addr[i] = {1'b0, phys} + 17'(i);
            active[i]    = (3'(i) < size_c);
            in_mem[i]    = (byte_addr[i] < 17'(MEM_BYTES));
            bad[i]       = absent || (byte_addr[i] < {1'b0, base}) ||
                           (byte_addr[i] >= limit) || !in_mem[i];
            wr_chain     = wr_chain && active[i] && !bad[i];
            wr_en[i]     = wr_chain;
            rd_en[i]     = !is_write && !seg_fault && active[i] &&
                           (fetch ? in_mem[i] : !bad[i]);
            pos          = 2'(size_c - 3'(i) - 3'd1);
            wbyte[i]     = write_data[{pos, 3'b000} +: 8];
        end
    end

    // classified item
    always_comb
    begin
        item.is_write  = is_write;
        item.fault     = seg_fault || (!fetch && |(active & bad));
        item.load_regs = !seg_fault && !fetch;
        item.size      = size_c;
        item.laddr     = logical_addr;
        item.phys      = phys;
        item.wdata     = write_data;
        item.wr_en     = wr_en;
        item.rd_en     = rd_en;
        item.wbyte     = wbyte;
    end

endmodule

// ----- rtl/smau_queue.sv -----
// two-entry queue between the front end and the back end
module smau_queue (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        push,
    input  smau_pkg::smau_item_t        push_item,
    input  logic                        pop,
    output smau_pkg::smau_item_t        head,
    output smau_pkg::smau_q_status_t    status
);
    import smau_pkg::*;

    smau_item_t         entry_reg [QUEUE_DEPTH];
    logic [QPTR_W-1:0]  wr_ptr_reg;
    logic [QPTR_W-1:0]  wr_ptr_next;
    logic [QPTR_W-1:0]  rd_ptr_reg;
    logic [QPTR_W-1:0]  rd_ptr_next;
    logic [QCNT_W-1:0]  count_reg;
    logic [QCNT_W-1:0]  count_next;
    logic               do_push;
    logic               do_pop;

    assign status.full  = (count_reg == QCNT_W'(QUEUE_DEPTH));
    assign status.empty = (count_reg == '0);
    assign do_push      = push && !status.full;
    assign do_pop       = pop && !status.empty;
    assign head         = entry_reg[rd_ptr_reg];

    // pointer and count update
    always_comb
    begin
        wr_ptr_next = do_push ? wr_ptr_reg + 1'b1 : wr_ptr_reg;
        rd_ptr_next = do_pop ? rd_ptr_reg + 1'b1 : rd_ptr_reg;
        count_next  = count_reg;
        if (do_push && !do_pop)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (do_pop && !do_push)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    // entry storage
    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            entry_reg[wr_ptr_reg] <= push_item;
        end
    end

endmodule

// ----- rtl/smau_back.sv -----
// back end: four byte-lane memory banks, result assembly and state registers
module smau_back #(
    parameter int MEM_BYTES = 16384
) (
    input  logic                    clk,
    input  logic                    rst_n,
    input  logic                    issue,
    input  smau_pkg::smau_item_t    head,
    output logic                    done,
    output logic [31:0]             read_data,
    output logic                    fault,
    output logic [31:0]             last_logical,
    output logic [31:0]             last_access_word,
    output logic [31:0]             last_buffer
);
    import smau_pkg::*;

    localparam int BANK_DEPTH = (MEM_BYTES + LANES - 1) / LANES;
    localparam int ROW_W      = $clog2(BANK_DEPTH);

    logic [7:0]   bank_rdata [LANES];
    logic         exec_valid_reg;
    smau_item_t   exec_item_reg;
    logic [31:0]  data;
    logic [1:0]   bank_sel;
    logic [1:0]   pos;
    logic [7:0]   lane_byte;
    logic         done_reg;
    logic [31:0]  read_data_reg;
    logic         fault_reg;
    logic [31:0]  logical_reg;
    logic [31:0]  access_word_reg;
    logic [31:0]  buffer_reg;

    // byte-lane banks: bank k holds the addresses whose low two bits are k
    for (genvar k = 0; k < LANES; k++)
    begin : g_bank
        logic [7:0]        mem [BANK_DEPTH];
        logic [1:0]        lane;
        logic [16:0]       addr;
        logic [ROW_W-1:0]  row;
        logic              we;
        logic [7:0]        rd_byte_reg;

        assign lane = 2'(k) - head.phys[1:0];
        assign addr = {1'b0, head.phys} + 17'(lane);
        assign row  = addr[ROW_W+1:2];
        assign we   = issue && head.wr_en[lane];

        always_ff @(posedge clk)
        begin
            if (we)
            begin
                mem[row] <= head.wbyte[lane];
            end
            rd_byte_reg <= mem[row];
        end

        assign bank_rdata[k] = rd_byte_reg;
    end

    // execute stage tracks the item whose bank reads are in flight
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            exec_valid_reg <= 1'b0;
        end
        else
        begin
            exec_valid_reg <= issue;
        end
    end

    always_ff @(posedge clk)
    begin
        if (issue)
        begin
            exec_item_reg <= head;
        end
    end

    // big-endian assembly of the bytes that passed
    always_comb
    begin
        data = '0;
        for (int i = 0; i < LANES; i++)
        begin
            bank_sel  = exec_item_reg.phys[1:0] + 2'(i);
            pos       = 2'(exec_item_reg.size - 3'(i) - 3'd1);
            lane_byte = bank_rdata[bank_sel] & {8{exec_item_reg.rd_en[i]}};
            data      = data | (32'(lane_byte) << {pos, 3'b000});
        end
    end

    // result strobe and state registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            done_reg        <= 1'b0;
            logical_reg     <= '0;
            access_word_reg <= '0;
            buffer_reg      <= '0;
        end
        else
        begin
            done_reg <= exec_valid_reg;
            if (exec_valid_reg && exec_item_reg.load_regs)
            begin
                logical_reg     <= exec_item_reg.laddr;
                access_word_reg <= {13'd0, exec_item_reg.size, exec_item_reg.phys};
                if (exec_item_reg.is_write)
                begin
                    buffer_reg <= exec_item_reg.wdata;
                end
                else if (!exec_item_reg.fault)
                begin
                    buffer_reg <= data;
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (exec_valid_reg)
        begin
            read_data_reg <= data;
            fault_reg     <= exec_item_reg.fault;
        end
    end

    assign done             = done_reg;
    assign read_data        = read_data_reg;
    assign fault            = fault_reg;
    assign last_logical     = logical_reg;
    assign last_access_word = access_word_reg;
    assign last_buffer      = buffer_reg;

endmodule

// ----- rtl/segmented_memory_access_unit_core.sv -----
// top level of the segmented memory access unit
// Usage:
//   An access is taken at a rising edge with start high and busy low; its fields are
//   op, logical_addr, access_size, write_data and is_fetch. The segment table is
//   loaded through cfg_we / cfg_index / cfg_wdata, one entry per write, while idle.
//   Each access yields one result: done is high for exactly one cycle with read_data,
//   fault and the register view last_logical / last_access_word / last_buffer.
//   done rises once the access has passed the queue, the execute stage and the result registers.
//   Throughput: one access per cycle; the front translates and checks all four bytes
//   at once, and four byte-lane banks serve all bytes of the access together,
//   with the bank read data registered before the result is formed.
//   A two-entry queue separates the front from the back; the back drains it every
//   cycle, so busy only rises if the queue fills.
//   The receiver cannot stall: results are presented once and not held.
//   Reset clears the queue, the pipeline, the three state registers (to zero) and
//   marks every segment absent; memory contents are undefined until written.
module segmented_memory_access_unit_core #(
    parameter int MEM_BYTES = 16384,
    parameter int SEGMENTS  = 8
) (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            start,
    output logic                            busy,
    output logic                            done,
    input  logic                            cfg_we,
    input  logic [smau_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  logic [31:0]                     cfg_wdata,
    input  logic                            op,
    input  logic [31:0]                     logical_addr,
    input  logic [2:0]                      access_size,
    input  logic [31:0]                     write_data,
    input  logic                            is_fetch,
    output logic [31:0]                     read_data,
    output logic                            fault,
    output logic [31:0]                     last_logical,
    output logic [31:0]                     last_access_word,
    output logic [31:0]                     last_buffer
);
    import smau_pkg::*;

    smau_item_t      front_item;
    smau_item_t      head_item;
    smau_q_status_t  q_status;
    logic            push;
    logic            issue;

    assign busy  = q_status.full;
    assign push  = start && !busy;
    assign issue = !q_status.empty;

    // translation and checks
    smau_front #(
        .MEM_BYTES (MEM_BYTES),
        .SEGMENTS  (SEGMENTS)
    ) u_front (
        .clk          (clk),
        .rst_n        (rst_n),
        .cfg_we       (cfg_we),
        .cfg_index    (cfg_index),
        .cfg_wdata    (cfg_wdata),
        .op           (op),
        .logical_addr (logical_addr),
        .access_size  (access_size),
        .write_data   (write_data),
        .is_fetch     (is_fetch),
        .item         (front_item)
    );

    // decoupling queue
    smau_queue u_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .push_item (front_item),
        .pop       (issue),
        .head      (head_item),
        .status    (q_status)
    );

    // memory access and result
    smau_back #(
        .MEM_BYTES (MEM_BYTES)
    ) u_back (
        .clk              (clk),
        .rst_n            (rst_n),
        .issue            (issue),
        .head             (head_item),
        .done             (done),
        .read_data        (read_data),
        .fault            (fault),
        .last_logical     (last_logical),
        .last_access_word (last_access_word),
        .last_buffer      (last_buffer)
    );

endmodule

// ----- rtl/smau_checker.sv -----
// port-level checker for the segmented memory access unit, bound to the top level
`include "segmented_memory_access_unit_core_macros.svh"

module smau_checker (
    input logic         clk,
    input logic         rst_n,
    input logic         start,
    input logic         busy,
    input logic         done,
    input logic         op,
    input logic         is_fetch,
    input logic [31:0]  read_data,
    input logic [31:0]  last_logical,
    input logic [31:0]  last_access_word,
    input logic [31:0]  last_buffer
);
    import smau_pkg::*;

    // one result per accepted transfer
    `SMAU_ASSERT_IMPL(a_fixed_latency, clk, rst_n, 1'b1, done == $past(start && !busy && rst_n, 3), "result strobe does not match accepted transfer")

    // writes return zero read data
    `SMAU_ASSERT_IMPL(a_write_zero_data, clk, rst_n, done && $past(start && !busy && op == OP_WRITE, 3), read_data == 32'd0, "write returned nonzero read data")

    // fetches leave the state registers alone
    `SMAU_ASSERT_IMPL(a_fetch_keeps_regs, clk, rst_n, done && $past(start && !busy && op == OP_READ && is_fetch, 3), $stable(last_logical) && $stable(last_access_word) && $stable(last_buffer), "fetch changed state registers")

    // state registers only move with a result
    `SMAU_ASSERT_IMPL(a_regs_move_with_result, clk, rst_n, !$stable(last_logical) || !$stable(last_access_word) || !$stable(last_buffer), done, "state register changed without a result")

    // back end drains the queue every cycle
    `SMAU_ASSERT_NEXT(a_never_busy_after_transfer, clk, rst_n, start && !busy, !busy, "queue filled up")

endmodule

bind segmented_memory_access_unit_core smau_checker u_smau_checker (.*);

// ----- test/tb.sv -----
// self-checking testbench for the segmented memory access unit core
module tb;
    import smau_pkg::*;

    localparam int CLK_PERIOD   = 10;
    localparam int MEM_SIZE     = 16384;
    localparam int SEG_COUNT    = 8;
    localparam int IDLE_PCT     = 37;
    localparam int DRAIN_CYCLES = 6;
    localparam int STALL_LIMIT  = 1000;
    localparam int PHASES       = 5;
    localparam int PHASE_ITEMS  = 360;
    localparam int SHOW_ERRORS  = 10;

    typedef struct {
        smau_op_t    op;
        logic [31:0] laddr;
        logic [2:0]  size;
        logic [31:0] wdata;
        logic        fetch;
    } access_t;

    typedef struct {
        logic [31:0] rdata;
        logic        fault;
        logic [31:0] last_laddr;
        logic [31:0] last_word;
        logic [31:0] last_buf;
    } access_result_t;

    logic                 clk = 1'b0;
    logic                 rst_n = 1'b0;
    logic                 start = 1'b0;
    logic                 busy;
    logic                 done;
    logic                 cfg_we = 1'b0;
    logic [CFG_IDX_W-1:0] cfg_index = '0;
    logic [31:0]          cfg_wdata = '0;
    logic                 op = 1'b0;
    logic [31:0]          logical_addr = '0;
    logic [2:0]           access_size = '0;
    logic [31:0]          write_data = '0;
    logic                 is_fetch = 1'b0;
    logic [31:0]          read_data;
    logic                 fault;
    logic [31:0]          last_logical;
    logic [31:0]          last_access_word;
    logic [31:0]          last_buffer;

    // predicted block state
    logic [31:0] seg_table [SEG_COUNT];
    logic [7:0]  shadow_mem [MEM_SIZE];
    logic [31:0] laddr_reg;
    logic [31:0] word_reg;
    logic [31:0] buf_reg;

    // generator view of which bytes hold known data
    bit          written_map [MEM_SIZE];
    logic [31:0] next_segments [SEG_COUNT];

    access_t        pending_access_q [$];
    access_result_t expected_result_q [$];
    access_t        cur_access;
    int unsigned    queued_count = 0;
    int unsigned    accepted_count = 0;
    int unsigned    error_count = 0;
    int unsigned    stall_cycles = 0;
    bit             sender_idles = 1'b1;

    segmented_memory_access_unit_core u_dut (
        .clk              (clk),
        .rst_n            (rst_n),
        .start            (start),
        .busy             (busy),
        .done             (done),
        .cfg_we           (cfg_we),
        .cfg_index        (cfg_index),
        .cfg_wdata        (cfg_wdata),
        .op               (op),
        .logical_addr     (logical_addr),
        .access_size      (access_size),
        .write_data       (write_data),
        .is_fetch         (is_fetch),
        .read_data        (read_data),
        .fault            (fault),
        .last_logical     (last_logical),
        .last_access_word (last_access_word),
        .last_buffer      (last_buffer)
    );

    always #(CLK_PERIOD / 2) clk = ~clk;

    // byte check against segment bounds and memory end, limit not truncated
    function automatic bit byte_blocked(input logic [31:0] entry, input int unsigned addr);
        int unsigned base;
        int unsigned limit;
        base  = entry[31:16];
        limit = base + entry[15:0];
        return entry == ABSENT_ENTRY || addr < base || addr >= limit || addr >= MEM_SIZE;
    endfunction

    function automatic logic [15:0] phys_start(input logic [31:0] entry,
                                               input logic [31:0] laddr);
        return entry[31:16] + laddr[15:0];
    endfunction

    function automatic logic [2:0] clamp_size(input logic [2:0] size);
        return (size > SIZE_MAX) ? SIZE_MAX : size;
    endfunction

    // translate one access, update the predicted state, produce its result
    task automatic segment_access(input access_t a, output access_result_t r);
        logic [31:0] entry;
        logic [15:0] phys;
        logic [2:0]  sz;
        logic [31:0] data;
        int unsigned addr;
        int          shift;
        bit          fetch_rd;
        bit          flt;
        sz       = clamp_size(a.size);
        fetch_rd = a.fetch && a.op == OP_READ;
        data     = '0;
        flt      = 1'b0;
        if (a.laddr[31:16] >= SEG_COUNT) begin
            flt = 1'b1;
        end
        else begin
            entry = seg_table[a.laddr[31:16]];
            phys  = phys_start(entry, a.laddr);
            if (!fetch_rd) begin
                laddr_reg = a.laddr;
                word_reg  = {13'd0, sz, phys};
            end
            if (a.op == OP_WRITE) begin
                // stores stop at the first faulting byte
                buf_reg = a.wdata;
                for (int i = 0; i < sz; i++) begin
                    addr  = phys + i;
                    shift = (int'(sz) - 1 - i) * 8;
                    if (byte_blocked(entry, addr)) begin
                        flt = 1'b1;
                        break;
                    end
                    shadow_mem[addr] = 8'(a.wdata >> shift);
                end
            end
            else begin
                // each read byte checked on its own, faulting bytes give zero
                for (int i = 0; i < sz; i++) begin
                    addr  = phys + i;
                    shift = (int'(sz) - 1 - i) * 8;
                    if (fetch_rd) begin
                        if (addr < MEM_SIZE)
                            data |= {24'd0, shadow_mem[addr]} << shift;
                    end
                    else if (byte_blocked(entry, addr)) begin
                        flt = 1'b1;
                    end
                    else begin
                        data |= {24'd0, shadow_mem[addr]} << shift;
                    end
                end
                if (!fetch_rd && !flt)
                    buf_reg = data;
            end
        end
        r.rdata      = data;
        r.fault      = flt;
        r.last_laddr = laddr_reg;
        r.last_word  = word_reg;
        r.last_buf   = buf_reg;
    endtask

    // true when a read would touch a byte never stored
    function automatic bit reads_unwritten(input access_t a);
        logic [31:0] entry;
        logic [15:0] phys;
        int unsigned addr;
        if (a.op == OP_WRITE || a.laddr[31:16] >= SEG_COUNT)
            return 1'b0;
        entry = seg_table[a.laddr[31:16]];
        phys  = phys_start(entry, a.laddr);
        for (int i = 0; i < clamp_size(a.size); i++) begin
            addr = phys + i;
            if (a.fetch ? addr < MEM_SIZE : !byte_blocked(entry, addr)) begin
                if (!written_map[addr])
                    return 1'b1;
            end
        end
        return 1'b0;
    endfunction

    // reads of unknown bytes become writes; track bytes that get stored
    task automatic queue_access(input access_t a);
        logic [31:0] entry;
        logic [15:0] phys;
        int unsigned addr;
        if (reads_unwritten(a))
            a.op = OP_WRITE;
        if (a.op == OP_WRITE && a.laddr[31:16] < SEG_COUNT) begin
            entry = seg_table[a.laddr[31:16]];
            phys  = phys_start(entry, a.laddr);
            for (int i = 0; i < clamp_size(a.size); i++) begin
                addr = phys + i;
                if (byte_blocked(entry, addr))
                    break;
                written_map[addr] = 1'b1;
            end
        end
        pending_access_q.push_back(a);
        queued_count++;
    endtask

    function automatic access_t make_access(input smau_op_t kind, input logic [31:0] laddr,
                                            input logic [2:0] size, input logic [31:0] wdata,
                                            input logic fetch);
        access_t a;
        a.op    = kind;
        a.laddr = laddr;
        a.size  = size;
        a.wdata = wdata;
        a.fetch = fetch;
        return a;
    endfunction

    function automatic logic [31:0] random_segment();
        int unsigned base;
        int unsigned span;
        case ($urandom_range(0, 9))
            0: return ABSENT_ENTRY;
            1: begin
                case ($urandom_range(0, 3))
                    0: return 32'h0000_0000;
                    1: return 32'hFFFF_FFFE;
                    2: return 32'h0000_FFFF;
                    default: return 32'hFFFF_0000;
                endcase
            end
            2: return $urandom();
            3, 4: begin
                base = $urandom_range(MEM_SIZE - 300, MEM_SIZE - 1);
                span = $urandom_range(1, 'h400);
            end
            default: begin
                base = $urandom_range(0, 'h3FF);
                span = $urandom_range(1, 'h200);
            end
        endcase
        return {16'(base), 16'(span)};
    endfunction

    function automatic access_t random_access();
        access_t     a;
        logic [15:0] seg_idx;
        logic [15:0] offset;
        int unsigned span;
        int unsigned pick;
        a.op    = ($urandom_range(0, 99) < 50) ? OP_WRITE : OP_READ;
        a.fetch = ($urandom_range(0, 3) == 0);
        a.wdata = $urandom();
        a.size  = ($urandom_range(0, 9) < 8) ? 3'($urandom_range(1, 4))
                                             : 3'($urandom_range(0, 7));
        pick = $urandom_range(0, 99);
        if (pick < 88)
            seg_idx = 16'($urandom_range(0, SEG_COUNT - 1));
        else if (pick < 95)
            seg_idx = 16'($urandom_range(SEG_COUNT, 'hFFFF));
        else
            seg_idx = 16'($urandom());
        span = (seg_idx < SEG_COUNT) ? seg_table[seg_idx][15:0] : 'hFFFF;
        if ($urandom_range(0, 99) < 85)
            offset = 16'($urandom_range(0, span + 3));
        else
            offset = 16'($urandom());
        a.laddr = {seg_idx, offset};
        return a;
    endfunction

    // segment table writes, only while nothing is in flight
    task automatic load_segments();
        for (int i = 0; i < SEG_COUNT; i++) begin
            @(posedge clk);
            cfg_we       <= 1'b1;
            cfg_index    <= CFG_IDX_W'(i);
            cfg_wdata    <= next_segments[i];
            seg_table[i] = next_segments[i];
        end
        @(posedge clk);
        cfg_we <= 1'b0;
    endtask

    task automatic wait_drained();
        while (accepted_count != queued_count || expected_result_q.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
    endtask

    // driver: predict on each accepted transfer, then offer the next one
    always @(posedge clk or negedge rst_n) begin
        access_result_t res;
        if (!rst_n) begin
            start        <= 1'b0;
            op           <= 1'b0;
            logical_addr <= '0;
            access_size  <= '0;
            write_data   <= '0;
            is_fetch     <= 1'b0;
        end
        else begin
            if (start && !busy) begin
                segment_access(cur_access, res);
                expected_result_q.push_back(res);
                accepted_count++;
            end
            if (!start || !busy) begin
                if (pending_access_q.size() != 0 &&
                    (!sender_idles || $urandom_range(0, 99) >= IDLE_PCT)) begin
                    cur_access   = pending_access_q.pop_front();
                    start        <= 1'b1;
                    op           <= cur_access.op;
                    logical_addr <= cur_access.laddr;
                    access_size  <= cur_access.size;
                    write_data   <= cur_access.wdata;
                    is_fetch     <= cur_access.fetch;
                end
                else begin
                    start <= 1'b0;
                end
            end
        end
    end

    // monitor: each result against the oldest prediction
    always @(posedge clk) begin
        access_result_t want;
        if (rst_n && done) begin
            if (expected_result_q.size() == 0) begin
                error_count++;
                if (error_count <= SHOW_ERRORS)
                    $display("result with no transfer pending: rdata=%h fault=%b",
                             read_data, fault);
            end
            else begin
                want = expected_result_q.pop_front();
                if (read_data !== want.rdata || fault !== want.fault ||
                    last_logical !== want.last_laddr || last_access_word !== want.last_word ||
                    last_buffer !== want.last_buf) begin
                    error_count++;
                    if (error_count <= SHOW_ERRORS)
                        $display("mismatch exp rdata=%h fault=%b laddr=%h word=%h buf=%h\n%s%h%s%b%s%h%s%h%s%h",
                                 want.rdata, want.fault, want.last_laddr, want.last_word,
                                 want.last_buf, "         got rdata=", read_data, " fault=",
                                 fault, " laddr=", last_logical, " word=", last_access_word,
                                 " buf=", last_buffer);
                end
            end
        end
    end

    // watchdog on cycles with no transfer on either side
    always @(posedge clk) begin
        if (!rst_n || (start && !busy) || done) begin
            stall_cycles <= 0;
        end
        else if (stall_cycles >= STALL_LIMIT) begin
            $display("CHECK FAILED");
            $finish;
        end
        else begin
            stall_cycles <= stall_cycles + 1;
        end
    end

    initial begin
        foreach (seg_table[i]) seg_table[i] = ABSENT_ENTRY;
        foreach (written_map[i]) written_map[i] = 1'b0;
        foreach (shadow_mem[i]) shadow_mem[i] = 8'h00;
        laddr_reg = '0;
        word_reg  = '0;
        buf_reg   = '0;
        rst_n     = 1'b0;
        repeat (4) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // reset table: absent entries, index out of table, fetch past memory end
        queue_access(make_access(OP_READ, 32'h0000_0000, 3'd4, 32'h0, 1'b0));
        queue_access(make_access(OP_WRITE, 32'h0008_0000, 3'd4, 32'hFFFF_FFFF, 1'b0));
        queue_access(make_access(OP_READ, 32'hFFFF_FFFF, 3'd1, 32'h0, 1'b1));
        queue_access(make_access(OP_READ, 32'h0003_4001, 3'd4, 32'h0, 1'b1));
        wait_drained();

        // directed table: small, bounded, memory end, zero size, absent, odd extremes
        next_segments = '{32'h0000_0100, 32'h0100_0010, 32'h3FF0_0100, 32'h0000_0000,
                          ABSENT_ENTRY, 32'hFFFF_FFFE, 32'h0200_FFFF, 32'h1000_0040};
        load_segments();
        queue_access(make_access(OP_WRITE, 32'h0000_0000, 3'd4, 32'hDEAD_BEEF, 1'b0));
        queue_access(make_access(OP_READ, 32'h0000_0000, 3'd4, 32'h0, 1'b0));
        queue_access(make_access(OP_READ, 32'h0000_0001, 3'd2, 32'h0, 1'b0));
        queue_access(make_access(OP_READ, 32'h0000_0000, 3'd3, 32'h0, 1'b1));
        // zero and oversized access sizes
        queue_access(make_access(OP_WRITE, 32'h0000_0004, 3'd0, 32'hFFFF_FFFF, 1'b0));
        queue_access(make_access(OP_READ, 32'h0000_0000, 3'd0, 32'h0, 1'b0));
        queue_access(make_access(OP_WRITE, 32'h0000_0008, 3'd7, 32'h0123_4567, 1'b0));
        queue_access(make_access(OP_READ, 32'h0000_0008, 3'd5, 32'h0, 1'b0));
        // partial write and partial read across the segment end
        queue_access(make_access(OP_WRITE, 32'h0001_000E, 3'd4, 32'hA5A5_A5A5, 1'b0));
        queue_access(make_access(OP_READ, 32'h0001_000E, 3'd4, 32'h0, 1'b0));
        // address below base after offset wrap
        queue_access(make_access(OP_READ, 32'h0001_FF00, 3'd1, 32'h0, 1'b0));
        // memory end: store stops there, fetch reads zero beyond it
        queue_access(make_access(OP_WRITE, 32'h0002_000C, 3'd4, 32'h0000_0000, 1'b0));
        queue_access(make_access(OP_WRITE, 32'h0002_000E, 3'd4, 32'h1122_3344, 1'b0));
        queue_access(make_access(OP_READ, 32'h0002_000E, 3'd4, 32'h0, 1'b1));
        queue_access(make_access(OP_READ, 32'h0003_0000, 3'd1, 32'h0, 1'b0));
        queue_access(make_access(OP_WRITE, 32'h0005_0001, 3'd2, 32'hFFFF_FFFF, 1'b0));
        // fetch flag ignored on a write
        queue_access(make_access(OP_WRITE, 32'h0007_0000, 3'd4, 32'h8000_0001, 1'b1));
        queue_access(make_access(OP_READ, 32'h0007_0000, 3'd4, 32'h0, 1'b1));
        queue_access(make_access(OP_READ, 32'h0004_0010, 3'd2, 32'h0, 1'b0));
        queue_access(make_access(OP_WRITE, 32'h0006_FFFF, 3'd4, 32'h5A5A_5A5A, 1'b0));
        wait_drained();

        // random phases, each with a fresh segment table
        for (int p = 0; p < PHASES; p++) begin
            foreach (next_segments[i]) next_segments[i] = random_segment();
            load_segments();
            sender_idles = (p != 2);
            for (int n = 0; n < PHASE_ITEMS; n++) begin
                // sender holds off until every result is back
                if (p == 1 && n == PHASE_ITEMS / 2)
                    wait_drained();
                queue_access(random_access());
            end
            wait_drained();
        end

        if (expected_result_q.size() != 0)
            error_count++;
        if (error_count == 0)
            $display("CHECK OK");
        else
            $display("CHECK FAILED");
        $finish;
    end
endmodule
